// ===== sv/segment_list_range_query_assert.svh =====
// Assertion macros for the segment list range query block.
// Used by segment_list_range_query.sv; expects signals named clock and reset in scope.
`ifndef SEGMENT_LIST_RANGE_QUERY_ASSERT_SVH
`define SEGMENT_LIST_RANGE_QUERY_ASSERT_SVH

// Same-cycle implication, checked outside of reset.
`define SLRQ_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside of reset.
`define SLRQ_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/slrq_pkg.sv =====
// Shared types and constants for the segment list range query block.
// No dependencies; used by the top level and by slrq_rsp_stage.
package slrq_pkg;

   localparam int TABLE_DEPTH_DEF = 64;
   localparam int TIME_W          = 64;
   localparam int STATUS_W        = 2;

   // Operation codes carried on req_tuser.
   localparam logic OP_APPEND = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_APPENDED = 2'd0,
      ST_FULL     = 2'd1,
      ST_SEGMENT  = 2'd2,
      ST_NONE     = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_EMIT_RD,
      S_EMIT_CHK,
      S_REPLY
   } state_type;

   typedef struct packed {
      status_type         status;
      logic [TIME_W-1:0]  start;
      logic [TIME_W-1:0]  stop;
      logic               last;
   } rsp_item_type;

endpackage

// ===== sv/slrq_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module slrq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/slrq_rsp_stage.sv =====
// Output register for the result channel of the segment list range query block.
// Depends on slrq_pkg for the result item type.
module slrq_rsp_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  slrq_pkg::rsp_item_type item,
   output logic                  free,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [127:0]          rsp_tdata,   // out_start [63:0], out_stop [127:64]
   output logic [1:0]            rsp_tuser,   // status [1:0]
   output logic                  rsp_tlast
);

   logic                   valid_ff;
   slrq_pkg::rsp_item_type item_ff;

   // The register can take a new item when empty or when its item leaves now.
   assign free = !valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (free) begin
         valid_ff <= load;
      end
   end

   always_ff @(posedge clock) begin
      if (load && free) begin
         item_ff <= item;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {item_ff.stop, item_ff.start};
   assign rsp_tuser  = item_ff.status;
   assign rsp_tlast  = item_ff.last;

endmodule

// ===== sv/segment_list_range_query.sv =====
// Top level of the segment list range query block: control sequencer and segment table.
// Depends on slrq_pkg, slrq_ram, slrq_rsp_stage and segment_list_range_query_assert.svh.
//
//   Channel   Direction  Ports          Contents
//   req_      in         tvalid/tready  tuser: operation; tdata: first_time, second_time
//   rsp_      out        tvalid/tready  tuser: status; tdata: out_start, out_stop; tlast
//
// An append uses the transfer cycle, in which the segment is written into the table RAM
// unless the table is full, then the reply state, which loads its result into the result register.
// A query over a table of n entries first runs the search pass (one RAM read issued per
// cycle, each start checked in the cycle after its read), then visits each entry from lo
// to hi (read, then check and emit), then loads the final result in the reply state;
// an empty table goes straight to the reply state.
// Reset is synchronous and active high; it empties the table (the count goes to zero).
// The RAM contents are not cleared, since entries at or above the count are never read.
// A stalled result channel holds the sequencer in place; no new request is taken until
// the last result of the current request has entered the result register.
`include "segment_list_range_query_assert.svh"

module segment_list_range_query #(
   parameter int TABLE_DEPTH = slrq_pkg::TABLE_DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,    // first_time [63:0], second_time [127:64]
   input  logic [0:0]   req_tuser,    // operation [0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,    // out_start [63:0], out_stop [127:64]
   output logic [1:0]   rsp_tuser,    // status [1:0]
   output logic         rsp_tlast
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int TW    = slrq_pkg::TIME_W;
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

   // Sequencer state.
   slrq_pkg::state_type  state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [TW-1:0]        t0_ff, t0_in;
   logic [TW-1:0]        t1_ff, t1_in;

   // Search pass: issue index, and the index whose read data is on the RAM output.
   logic [CNT_W-1:0]     iss_ff, iss_in;
   logic                 chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]     chk_idx_ff, chk_idx_in;
   logic [IDX_W-1:0]     lo_ff, lo_in;
   logic [IDX_W-1:0]     hi_ff, hi_in;
   logic                 lo_fnd_ff, lo_fnd_in;
   logic                 hi_fnd_ff, hi_fnd_in;
   logic [IDX_W-1:0]     lo_eff;

   // Emit pass: current index and the one-deep hold of the previous matching segment.
   logic [IDX_W-1:0]     idx_ff, idx_in;
   slrq_pkg::status_type pend_status_ff, pend_status_in;
   logic [TW-1:0]        pend_start_ff, pend_start_in;
   logic [TW-1:0]        pend_stop_ff, pend_stop_in;

   // Table RAM: one word holds {stop, start} of a segment.
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   logic [2*TW-1:0]      wr_data;
   logic                 rd_en;
   logic [IDX_W-1:0]     rd_addr;
   logic [2*TW-1:0]      rd_data;
   logic [TW-1:0]        ent_start;
   logic [TW-1:0]        ent_stop;

   logic                   req_accept;
   logic                   out_free;
   logic                   out_load;
   slrq_pkg::rsp_item_type out_item;

   slrq_ram #(
      .WIDTH (2 * TW),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   slrq_rsp_stage u_rsp (
      .clock      (clock),
      .reset      (reset),
      .load       (out_load),
      .item       (out_item),
      .free       (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   assign req_tready = (state_ff == slrq_pkg::S_IDLE);
   assign req_accept = req_tvalid && req_tready;

   assign ent_start = rd_data[TW-1:0];
   assign ent_stop  = rd_data[2*TW-1:TW];

   // Appends always go to the slot just past the last stored segment.
   assign wr_addr = count_ff[IDX_W-1:0];
   assign wr_data = req_tdata;

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      t0_in          = t0_ff;
      t1_in          = t1_ff;
      iss_in         = iss_ff;
      chk_vld_in     = chk_vld_ff;
      chk_idx_in     = chk_idx_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      lo_fnd_in      = lo_fnd_ff;
      hi_fnd_in      = hi_fnd_ff;
      idx_in         = idx_ff;
      pend_status_in = pend_status_ff;
      pend_start_in  = pend_start_ff;
      pend_stop_in   = pend_stop_ff;
      lo_eff         = '0;
      wr_en          = 1'b0;
      rd_en          = 1'b0;
      rd_addr        = idx_ff;
      out_load       = 1'b0;
      out_item       = '{status: pend_status_ff, start: pend_start_ff,
                         stop: pend_stop_ff, last: 1'b0};

      case (state_ff)
         slrq_pkg::S_IDLE: begin
            if (req_accept) begin
               t0_in         = req_tdata[TW-1:0];
               t1_in         = req_tdata[2*TW-1:TW];
               pend_start_in = '0;
               pend_stop_in  = '0;
               if (req_tuser[0] == slrq_pkg::OP_APPEND) begin
                  if (count_ff < DEPTH_CNT) begin
                     wr_en          = 1'b1;
                     count_in       = count_ff + CNT_W'(1);
                     pend_status_in = slrq_pkg::ST_APPENDED;
                  end else begin
                     pend_status_in = slrq_pkg::ST_FULL;
                  end
                  state_in = slrq_pkg::S_REPLY;
               end else begin
                  pend_status_in = slrq_pkg::ST_NONE;
                  lo_fnd_in      = 1'b0;
                  hi_fnd_in      = 1'b0;
                  iss_in         = '0;
                  chk_vld_in     = 1'b0;
                  if (count_ff == '0) begin
                     state_in = slrq_pkg::S_REPLY;
                  end else begin
                     state_in = slrq_pkg::S_SCAN;
                  end
               end
            end
         end

         slrq_pkg::S_SCAN: begin
            // Read one entry per cycle; its start is checked in the next cycle.
            if (iss_ff < count_ff) begin
               rd_en      = 1'b1;
               rd_addr    = iss_ff[IDX_W-1:0];
               iss_in     = iss_ff + CNT_W'(1);
               chk_vld_in = 1'b1;
               chk_idx_in = iss_ff[IDX_W-1:0];
            end else begin
               chk_vld_in = 1'b0;
            end
            if (chk_vld_ff) begin
               // Later entries overwrite earlier ones, so the last match wins.
               if (ent_start <= t0_ff) begin
                  lo_in     = chk_idx_ff;
                  lo_fnd_in = 1'b1;
               end
               if (ent_start <= t1_ff) begin
                  hi_in     = chk_idx_ff;
                  hi_fnd_in = 1'b1;
               end
               if (CNT_W'(chk_idx_ff) + CNT_W'(1) == count_ff) begin
                  // With no start at or before the window start, the scan begins at entry 0.
                  lo_eff = lo_fnd_in ? lo_in : '0;
                  if (hi_fnd_in && (hi_in >= lo_eff)) begin
                     idx_in   = lo_eff;
                     state_in = slrq_pkg::S_EMIT_RD;
                  end else begin
                     state_in = slrq_pkg::S_REPLY;
                  end
               end
            end
         end

         slrq_pkg::S_EMIT_RD: begin
            rd_en    = 1'b1;
            rd_addr  = idx_ff;
            state_in = slrq_pkg::S_EMIT_CHK;
         end

         slrq_pkg::S_EMIT_CHK: begin
            // The read data register holds while this state waits on the result channel.
            if (ent_stop >= t0_ff) begin
               if (pend_status_ff == slrq_pkg::ST_SEGMENT) begin
                  if (out_free) begin
                     out_load      = 1'b1;
                     pend_start_in = ent_start;
                     pend_stop_in  = ent_stop;
                  end
               end else begin
                  // First emitted segment: raise its start to the window start.
                  pend_status_in = slrq_pkg::ST_SEGMENT;
                  pend_start_in  = (ent_start < t0_ff) ? t0_ff : ent_start;
                  pend_stop_in   = ent_stop;
               end
            end
            if (!(ent_stop >= t0_ff) || (pend_status_ff != slrq_pkg::ST_SEGMENT) ||
                out_free) begin
               if (idx_ff == hi_ff) begin
                  state_in = slrq_pkg::S_REPLY;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = slrq_pkg::S_EMIT_RD;
               end
            end
         end

         slrq_pkg::S_REPLY: begin
            // Final result: the stop is lowered to the window stop. Non-segment results
            // carry zeros, which the clip leaves unchanged.
            out_item.stop = (pend_stop_ff > t1_ff) ? t1_ff : pend_stop_ff;
            out_item.last = 1'b1;
            if (out_free) begin
               out_load = 1'b1;
               state_in = slrq_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = slrq_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= slrq_pkg::S_IDLE;
         count_ff   <= '0;
         chk_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         chk_vld_ff <= chk_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      t0_ff          <= t0_in;
      t1_ff          <= t1_in;
      iss_ff         <= iss_in;
      chk_idx_ff     <= chk_idx_in;
      lo_ff          <= lo_in;
      hi_ff          <= hi_in;
      lo_fnd_ff      <= lo_fnd_in;
      hi_fnd_ff      <= hi_fnd_in;
      idx_ff         <= idx_in;
      pend_status_ff <= pend_status_in;
      pend_start_ff  <= pend_start_in;
      pend_stop_ff   <= pend_stop_in;
   end

   `SLRQ_ASSERT_IMP(a_count_bound, 1'b1, count_ff <= DEPTH_CNT, "entry count above table depth")
   `SLRQ_ASSERT_NXT(a_full_keeps_count,
      req_accept && (req_tuser[0] == slrq_pkg::OP_APPEND) && (count_ff == DEPTH_CNT),
      $stable(count_ff), "append to a full table changed the count")
   `SLRQ_ASSERT_NXT(a_reply_done, (state_ff == slrq_pkg::S_REPLY) && out_free,
      (state_ff == slrq_pkg::S_IDLE) && rsp_tvalid && rsp_tlast,
      "final result not delivered on leaving reply state")
   `SLRQ_ASSERT_IMP(a_emit_in_range,
      (state_ff == slrq_pkg::S_EMIT_RD) || (state_ff == slrq_pkg::S_EMIT_CHK),
      (idx_ff <= hi_ff) && (CNT_W'(idx_ff) < count_ff), "emit index outside the query range")

endmodule
